// ===== hdl/epoch_seconds_to_calendar_core_defines.svh =====
// assertion macros shared by the epoch seconds to calendar checker
// no dependencies; expects clk and rst in the scope of use
`ifndef EPOCH_SECONDS_TO_CALENDAR_CORE_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ESC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// next-cycle implication, disabled in reset
`define ESC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// ===== hdl/esc_pkg.sv =====
// shared types, constants and helper functions for the epoch seconds to calendar core
// no dependencies
package esc_pkg;

  // days: (stamp >> 7) / 675 by the reciprocal ceil(2^35 / 675)
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;
  localparam logic [9:0]  DAY_UNIT   = 10'd675;
  // hours: (second of day >> 4) / 225 by ceil(2^21 / 225)
  localparam logic [13:0] HOUR_RECIP = 14'd9321;
  localparam logic [7:0]  HOUR_UNIT  = 8'd225;
  // minutes: (second of hour >> 2) / 15 by ceil(2^14 / 15)
  localparam logic [10:0] MIN_RECIP  = 11'd1093;
  localparam logic [3:0]  MIN_UNIT   = 4'd15;
  localparam logic [7:0]  EPOCH_YEAR_OFS = 8'd70;
  localparam logic [7:0]  NONLEAP_CENTURY_OFS = 8'd200;
  localparam logic [2:0]  EPOCH_WEEKDAY = 3'd4;
  localparam logic [3:0]  LAST_MONTH = 4'd11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOUR,
    ST_MIN,
    ST_YEAR,
    ST_MONTH
  } state_t;

  typedef struct packed {
    logic       load;
    logic       div_step;
    logic       tod_step;
    logic       tod_min;
    logic       phase;
    logic       year_step;
    logic       month_load;
    logic       month_step;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } status_t;

  // leap rule on years since 1900, valid for 1901..2155
  function automatic logic is_leap(input logic [7:0] y);
    return (y[1:0] == 2'd0) && (y != NONLEAP_CENTURY_OFS);
  endfunction

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
      4'd1: len = leap ? 5'd29 : 5'd28;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [2:0] mod7_small(input logic [4:0] v);
    logic [4:0] r;
    if (v < 5'd7) begin
      r = v;
    end else if (v < 5'd14) begin
      r = v - 5'd7;
    end else if (v < 5'd21) begin
      r = v - 5'd14;
    end else if (v < 5'd28) begin
      r = v - 5'd21;
    end else begin
      r = v - 5'd28;
    end
    return r[2:0];
  endfunction

  function automatic logic [2:0] wd_add(input logic [2:0] a, input logic [2:0] b);
    logic [3:0] s;
    logic [3:0] r;
    s = {1'b0, a} + {1'b0, b};
    r = (s >= 4'd7) ? (s - 4'd7) : s;
    return r[2:0];
  endfunction

endpackage

// ===== hdl/epoch_seconds_to_calendar_core.sv =====
// epoch seconds to utc calendar fields, top level; depends on esc_pkg, esc_ctrl, esc_datapath
// one item at a time: start is taken only while idle; the year loop steps once for each
// whole year past 1970 (0..136) and the month loop once for each month before the month
// index (0..11), so the run time grows with the date
// busy is low again in the cycle that carries done, so a new start can be taken then
// synchronous active-high rst returns the controller to idle and clears done; results hold
module epoch_seconds_to_calendar_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] epoch_seconds,
  output logic        done,
  output logic [5:0]  second_of_minute,
  output logic [5:0]  minute_of_hour,
  output logic [4:0]  hour_of_day,
  output logic [4:0]  day_of_month,
  output logic [3:0]  month_index,
  output logic [7:0]  years_since_1900,
  output logic [2:0]  weekday,
  output logic [8:0]  day_of_year
);

  esc_pkg::cmd_t    cmd;
  esc_pkg::status_t status;

  esc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  esc_datapath u_dp (
    .clk              (clk),
    .epoch_seconds    (epoch_seconds),
    .cmd              (cmd),
    .status           (status),
    .second_of_minute (second_of_minute),
    .minute_of_hour   (minute_of_hour),
    .hour_of_day      (hour_of_day),
    .day_of_month     (day_of_month),
    .month_index      (month_index),
    .years_since_1900 (years_since_1900),
    .weekday          (weekday),
    .day_of_year      (day_of_year)
  );

endmodule

// ===== hdl/esc_ctrl.sv =====
// sequencing state machine: division, time of day, year and month loops
// depends on esc_pkg
module esc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  esc_pkg::status_t status,
  output esc_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done
);

  esc_pkg::state_t state;
  esc_pkg::state_t state_next;
  logic            phase;
  logic            phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= esc_pkg::ST_IDLE;
      phase <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      done  <= cmd.finish;
    end
  end

  // each division takes a quotient step, then a remainder step
  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd        = '0;
    case (state)
      esc_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          phase_next = 1'b0;
          state_next = esc_pkg::ST_DIV;
        end
      end
      esc_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.phase    = phase;
        if (phase) begin
          phase_next = 1'b0;
          state_next = esc_pkg::ST_HOUR;
        end else begin
          phase_next = 1'b1;
        end
      end
      esc_pkg::ST_HOUR: begin
        cmd.tod_step = 1'b1;
        cmd.phase    = phase;
        if (phase) begin
          phase_next = 1'b0;
          state_next = esc_pkg::ST_MIN;
        end else begin
          phase_next = 1'b1;
        end
      end
      esc_pkg::ST_MIN: begin
        cmd.tod_step = 1'b1;
        cmd.tod_min  = 1'b1;
        cmd.phase    = phase;
        if (phase) begin
          phase_next = 1'b0;
          state_next = esc_pkg::ST_YEAR;
        end else begin
          phase_next = 1'b1;
        end
      end
      esc_pkg::ST_YEAR: begin
        if (status.year_done) begin
          cmd.month_load = 1'b1;
          state_next     = esc_pkg::ST_MONTH;
        end else begin
          cmd.year_step = 1'b1;
        end
      end
      esc_pkg::ST_MONTH: begin
        if (status.month_done) begin
          cmd.finish = 1'b1;
          state_next = esc_pkg::ST_IDLE;
        end else begin
          cmd.month_step = 1'b1;
        end
      end
      default: begin
        state_next = esc_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state != esc_pkg::ST_IDLE);

endmodule

// ===== hdl/esc_datapath.sv =====
// datapath: reciprocal dividers, year and month subtraction, weekday tracking, result registers
// depends on esc_pkg
module esc_datapath (
  input  logic             clk,
  input  logic [31:0]      epoch_seconds,
  input  esc_pkg::cmd_t    cmd,
  output esc_pkg::status_t status,
  output logic [5:0]       second_of_minute,
  output logic [5:0]       minute_of_hour,
  output logic [4:0]       hour_of_day,
  output logic [4:0]       day_of_month,
  output logic [3:0]       month_index,
  output logic [7:0]       years_since_1900,
  output logic [2:0]       weekday,
  output logic [8:0]       day_of_year
);

  logic [31:0] stamp;
  logic [16:0] rem;
  logic [15:0] days;
  logic [4:0]  hour_acc;
  logic [5:0]  minute_acc;
  logic [7:0]  year;
  logic [2:0]  wd;
  logic [8:0]  mday;
  logic [3:0]  month;

  // day split
  logic [24:0] day_num;
  logic [50:0] day_prod;
  logic [9:0]  day_back;
  logic [9:0]  day_left;

  // hour split
  logic [12:0] hour_num;
  logic [25:0] hour_prod;
  logic [7:0]  hour_back;
  logic [7:0]  hour_left;

  // minute split
  logic [9:0]  min_num;
  logic [19:0] min_prod;
  logic [3:0]  min_back;
  logic [3:0]  min_left;

  // year and month step
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;

  assign day_num   = stamp[31:7];
  assign day_prod  = {26'd0, day_num} * {25'd0, esc_pkg::DAY_RECIP};
  // remainder is below the unit, so the low bits carry it exactly
  assign day_back  = days[9:0] * esc_pkg::DAY_UNIT;
  assign day_left  = day_num[9:0] - day_back;

  assign hour_num  = rem[16:4];
  assign hour_prod = {13'd0, hour_num} * {12'd0, esc_pkg::HOUR_RECIP};
  assign hour_back = {3'd0, hour_acc} * esc_pkg::HOUR_UNIT;
  assign hour_left = hour_num[7:0] - hour_back;

  assign min_num   = rem[11:2];
  assign min_prod  = {10'd0, min_num} * {9'd0, esc_pkg::MIN_RECIP};
  assign min_back  = minute_acc[3:0] * esc_pkg::MIN_UNIT;
  assign min_left  = min_num[3:0] - min_back;

  assign leap = esc_pkg::is_leap(year);
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = esc_pkg::month_len(leap, month);

  assign status.year_done  = (days < {7'd0, ylen});
  assign status.month_done = (month == esc_pkg::LAST_MONTH) || (mday < {4'd0, mlen});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      stamp <= epoch_seconds;
      year  <= esc_pkg::EPOCH_YEAR_OFS;
      wd    <= esc_pkg::EPOCH_WEEKDAY;
    end
    if (cmd.div_step) begin
      if (cmd.phase) begin
        rem <= {day_left, stamp[6:0]};
      end else begin
        days <= day_prod[50:35];
      end
    end
    if (cmd.tod_step) begin
      if (cmd.tod_min) begin
        if (cmd.phase) begin
          rem <= {11'd0, min_left, rem[1:0]};
        end else begin
          minute_acc <= min_prod[19:14];
        end
      end else begin
        if (cmd.phase) begin
          rem <= {5'd0, hour_left, rem[3:0]};
        end else begin
          hour_acc <= hour_prod[25:21];
        end
      end
    end
    if (cmd.year_step) begin
      days <= days - {7'd0, ylen};
      year <= year + 8'd1;
      wd   <= esc_pkg::wd_add(wd, leap ? 3'd2 : 3'd1);
    end
    if (cmd.month_load) begin
      mday  <= days[8:0];
      month <= 4'd0;
    end
    if (cmd.month_step) begin
      mday  <= mday - {4'd0, mlen};
      month <= month + 4'd1;
      wd    <= esc_pkg::wd_add(wd, esc_pkg::mod7_small(mlen));
    end
    if (cmd.finish) begin
      second_of_minute <= rem[5:0];
      minute_of_hour   <= minute_acc;
      hour_of_day      <= hour_acc;
      day_of_month     <= mday[4:0] + 5'd1;
      month_index      <= month;
      years_since_1900 <= year;
      weekday          <= esc_pkg::wd_add(wd, esc_pkg::mod7_small(mday[4:0]));
      day_of_year      <= days[8:0];
    end
  end

endmodule

// ===== hdl/esc_checker.sv =====
// port-level checker for the epoch seconds to calendar core, bound to the top level
// depends on epoch_seconds_to_calendar_core_defines.svh
`include "epoch_seconds_to_calendar_core_defines.svh"

module esc_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [31:0] epoch_seconds,
  input logic        done,
  input logic [5:0]  second_of_minute,
  input logic [5:0]  minute_of_hour,
  input logic [4:0]  hour_of_day,
  input logic [4:0]  day_of_month,
  input logic [3:0]  month_index,
  input logic [7:0]  years_since_1900,
  input logic [2:0]  weekday,
  input logic [8:0]  day_of_year
);

  `ESC_ASSERT_NOW(a_done_when_idle, done, !busy)
  `ESC_ASSERT_NEXT(a_start_goes_busy, start && !busy, busy && !done)
  `ESC_ASSERT_NEXT(a_done_single, done, !done)
  `ESC_ASSERT_NOW(a_time_range, done,
    (second_of_minute < 6'd60) && (minute_of_hour < 6'd60) && (hour_of_day < 5'd24))
  `ESC_ASSERT_NOW(a_date_range, done,
    (month_index < 4'd12) && (weekday < 3'd7) && (day_of_month != 5'd0) &&
    (day_of_year <= 9'd365) && (years_since_1900 >= 8'd70))

endmodule

bind epoch_seconds_to_calendar_core esc_checker u_esc_checker (.*);
